// ===== rtl/dep_pkg.sv =====
// Shared types and constants for the double-ended priority queue.
// No dependencies; imported by every module of the block.
package dep_pkg;

   localparam int CAPACITY = 16;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int IDX_W    = $clog2(CAPACITY);

   // Request opcodes
   localparam logic [1:0] MODE_INSERT     = 2'd0;
   localparam logic [1:0] MODE_REMOVE_MIN = 2'd1;
   localparam logic [1:0] MODE_REMOVE_MAX = 2'd2;

   // Response status codes
   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic signed [31:0] prio;
      logic [31:0]        pay;
   } entry_type;

   // Per-cell control from the top level
   typedef struct packed {
      logic insert;      // insert transaction, queue not full
      logic pop_head;    // remove-max, queue not empty
      logic occupied;    // cell index below the count
      logic first_free;  // cell index equal to the count
   } cell_ctl_type;

endpackage

// ===== rtl/dep_cell.sv =====
// One slot of the sorted cell chain: holds an entry, shifts toward
// the tail on insert, toward the head on remove-max. Uses dep_pkg.
module dep_cell (
   input  logic                 clock,
   input  dep_pkg::cell_ctl_type ctl,
   input  dep_pkg::entry_type    new_entry,
   input  dep_pkg::entry_type    left_entry,
   input  dep_pkg::entry_type    right_entry,
   input  logic                 left_after,
   output logic                 after,
   output dep_pkg::entry_type    entry
);
   import dep_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;
   logic      le;

   // Stored priority at or below the new one: new entry goes in front.
   assign le    = (entry_ff.prio <= new_entry.prio);
   assign after = ctl.occupied ? le : ctl.first_free;
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.insert) begin
         if (left_after) begin
            entry_in = left_entry;
         end else if (after) begin
            entry_in = new_entry;
         end
      end else if (ctl.pop_head) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// ===== rtl/double_ended_priority_queue.sv =====
// Double-ended priority queue: a row of CAPACITY cells sorted highest first.
// Timing: the cells update at the edge that accepts the request transaction;
// the response register is then loaded from the held state when not stalled.
// No request is taken while one is pending; the tail cell is read through one
// selector before the update (remove-min) and after it (bottom of the result).
// Reset: synchronous; clears the count and handshake state. Cell contents are
// not cleared; cells at or beyond the count are never shown.
module double_ended_priority_queue (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_mode,
   input  logic signed [31:0] req_new_priority,
   input  logic [31:0]        req_new_payload,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic               rsp_removed_valid,
   output logic signed [31:0] rsp_removed_priority,
   output logic [31:0]        rsp_removed_payload,
   output logic [4:0]         rsp_entry_count,
   output logic signed [31:0] rsp_top_priority,
   output logic [31:0]        rsp_top_payload,
   output logic signed [31:0] rsp_bottom_priority,
   output logic [31:0]        rsp_bottom_payload
);
   import dep_pkg::*;

   // ---------------------------------------------------------------------
   // Control state
   // ---------------------------------------------------------------------
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pending_ff, pending_in;   // update done, response not yet formed
   logic             rsp_valid_ff, rsp_valid_in;

   // Held between the update cycle and the response cycle
   logic [1:0]       stat_ff, stat_in;
   logic             rem_valid_ff, rem_valid_in;
   entry_type        rem_ff, rem_in;

   // Response register
   logic [1:0]       rsp_stat_ff;
   logic             rsp_rem_valid_ff;
   entry_type        rsp_rem_ff;
   logic [4:0]       rsp_count_ff;
   entry_type        rsp_top_ff, rsp_bot_ff;

   logic             accept;
   logic             out_free;
   logic             form_rsp;
   logic             full;
   logic             empty;
   logic             do_insert;
   logic             do_pop_head;
   logic [IDX_W-1:0] bottom_idx;
   entry_type        bottom_entry;
   entry_type        new_entry;

   // ---------------------------------------------------------------------
   // Cell chain
   // ---------------------------------------------------------------------
   entry_type    cell_q   [CAPACITY];
   logic         after_q  [CAPACITY];
   cell_ctl_type ctl_q    [CAPACITY];

   assign new_entry.prio = req_new_priority;
   assign new_entry.pay  = req_new_payload;

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      assign ctl_q[g].insert     = do_insert;
      assign ctl_q[g].pop_head   = do_pop_head;
      assign ctl_q[g].occupied   = (CNT_W'(g) < count_ff);
      assign ctl_q[g].first_free = (CNT_W'(g) == count_ff);

      if (g == 0) begin : g_head
         if (CAPACITY > 1) begin : g_mid
            dep_cell u_cell (
               .clock       (clock),
               .ctl         (ctl_q[g]),
               .new_entry   (new_entry),
               .left_entry  (new_entry),
               .right_entry (cell_q[g+1]),
               .left_after  (1'b0),
               .after       (after_q[g]),
               .entry       (cell_q[g])
            );
         end
      end else if (g == CAPACITY - 1) begin : g_tail
         // tail refill on a pop is never read: the count drops past it
         dep_cell u_cell (
            .clock       (clock),
            .ctl         (ctl_q[g]),
            .new_entry   (new_entry),
            .left_entry  (cell_q[g-1]),
            .right_entry (cell_q[g]),
            .left_after  (after_q[g-1]),
            .after       (after_q[g]),
            .entry       (cell_q[g])
         );
      end else begin : g_body
         dep_cell u_cell (
            .clock       (clock),
            .ctl         (ctl_q[g]),
            .new_entry   (new_entry),
            .left_entry  (cell_q[g-1]),
            .right_entry (cell_q[g+1]),
            .left_after  (after_q[g-1]),
            .after       (after_q[g]),
            .entry       (cell_q[g])
         );
      end
   end

   // ---------------------------------------------------------------------
   // Handshake
   // ---------------------------------------------------------------------
   assign req_stall = pending_ff;
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign form_rsp  = pending_ff && out_free;

   assign full  = (count_ff == CNT_W'(CAPACITY));
   assign empty = (count_ff == '0);

   // Tail cell select; wraps when empty, result masked below
   assign bottom_idx   = IDX_W'(count_ff - 1'b1);
   assign bottom_entry = cell_q[bottom_idx];

   // ---------------------------------------------------------------------
   // Update cycle: cells shift, count moves, removed entry captured
   // ---------------------------------------------------------------------
   always_comb begin
      do_insert    = 1'b0;
      do_pop_head  = 1'b0;
      count_in     = count_ff;
      stat_in      = stat_ff;
      rem_valid_in = rem_valid_ff;
      rem_in       = rem_ff;
      if (accept) begin
         stat_in      = STATUS_DONE;
         rem_valid_in = 1'b0;
         rem_in       = '0;
         case (req_mode)
            MODE_INSERT: begin
               if (full) begin
                  stat_in = STATUS_FULL;
               end else begin
                  do_insert = 1'b1;
                  count_in  = count_ff + 1'b1;
               end
            end
            MODE_REMOVE_MIN: begin
               if (empty) begin
                  stat_in = STATUS_EMPTY;
               end else begin
                  rem_valid_in = 1'b1;
                  rem_in       = bottom_entry;
                  count_in     = count_ff - 1'b1;
               end
            end
            MODE_REMOVE_MAX: begin
               if (empty) begin
                  stat_in = STATUS_EMPTY;
               end else begin
                  rem_valid_in = 1'b1;
                  rem_in       = cell_q[0];
                  do_pop_head  = 1'b1;
                  count_in     = count_ff - 1'b1;
               end
            end
            default: begin
               // unused opcode: no-op transaction
            end
         endcase
      end
   end

   // pending / response valid sequencing
   always_comb begin
      pending_in   = pending_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (form_rsp) begin
         pending_in   = 1'b0;
         rsp_valid_in = 1'b1;
      end
      if (accept) begin
         pending_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         pending_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers, no reset
   always_ff @(posedge clock) begin
      stat_ff      <= stat_in;
      rem_valid_ff <= rem_valid_in;
      rem_ff       <= rem_in;
      if (form_rsp) begin
         rsp_stat_ff      <= stat_ff;
         rsp_rem_valid_ff <= rem_valid_ff;
         rsp_rem_ff       <= rem_ff;
         rsp_count_ff     <= 5'(count_ff);
         rsp_top_ff       <= empty ? '0 : cell_q[0];
         rsp_bot_ff       <= empty ? '0 : bottom_entry;
      end
   end

   // ---------------------------------------------------------------------
   // Outputs
   // ---------------------------------------------------------------------
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_stat_ff;
   assign rsp_removed_valid    = rsp_rem_valid_ff;
   assign rsp_removed_priority = rsp_rem_ff.prio;
   assign rsp_removed_payload  = rsp_rem_ff.pay;
   assign rsp_entry_count      = rsp_count_ff;
   assign rsp_top_priority     = rsp_top_ff.prio;
   assign rsp_top_payload      = rsp_top_ff.pay;
   assign rsp_bottom_priority  = rsp_bot_ff.prio;
   assign rsp_bottom_payload   = rsp_bot_ff.pay;

endmodule

// ===== rtl/dep_checker.sv =====
// Port-level checks for the double-ended priority queue, bound to the top.
// Uses dep_pkg for capacity and status codes.
module dep_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [1:0]         rsp_status,
   input logic               rsp_removed_valid,
   input logic signed [31:0] rsp_removed_priority,
   input logic [31:0]        rsp_removed_payload,
   input logic [4:0]         rsp_entry_count,
   input logic signed [31:0] rsp_top_priority,
   input logic [31:0]        rsp_top_payload,
   input logic signed [31:0] rsp_bottom_priority,
   input logic [31:0]        rsp_bottom_payload
);
   import dep_pkg::*;

   // a stalled response transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_removed_valid)
         && $stable(rsp_removed_priority) && $stable(rsp_removed_payload)
         && $stable(rsp_top_priority) && $stable(rsp_top_payload)
         && $stable(rsp_bottom_priority) && $stable(rsp_bottom_payload)
         && $stable(rsp_entry_count))
      else $error("response changed while stalled");

   // removed entry only on a successful remove
   a_removed_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_removed_valid |-> rsp_status == STATUS_DONE)
      else $error("removed entry with error status");

   // refused insert only when the queue is full
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_FULL |-> rsp_entry_count == 5'(CAPACITY))
      else $error("full status below capacity");

   // empty queue shows zero head and tail
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_entry_count == 5'd0 && CAPACITY < 32 |->
         rsp_top_priority == 0 && rsp_bottom_priority == 0
         && rsp_top_payload == 0 && rsp_bottom_payload == 0
         && rsp_status != STATUS_FULL)
      else $error("empty queue shows entries");

   // sort order: head never below tail
   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_entry_count != 5'd0 |-> rsp_top_priority >= rsp_bottom_priority)
      else $error("head below tail");

endmodule

bind double_ended_priority_queue dep_checker u_dep_checker (.*);
